// ----- hw/rtl/sws_pkg.sv -----
// Shared constants and types for the key stack with blocker search.
package sws_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int KEY_WIDTH   = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W       = $clog2(STACK_DEPTH);

    // Request codes
    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_PUSHED    = 3'd0;
    localparam logic [2:0] KIND_POPPED    = 3'd1;
    localparam logic [2:0] KIND_OVERFLOW  = 3'd2;
    localparam logic [2:0] KIND_UNDERFLOW = 3'd3;
    localparam logic [2:0] KIND_BLOCKER   = 3'd4;
    localparam logic [2:0] KIND_DONE      = 3'd5;

    typedef struct packed {
        logic [2:0]           kind;
        logic                 found;
        logic [KEY_WIDTH-1:0] value;
        logic                 last;
    } out_beat_t;

endpackage

// ----- hw/rtl/stack_with_search_blockers.sv -----
// Bounded key stack with push, pop and a query that lists the blocking entries.
//
// Input channel (s_valid/s_ready): one request per beat, s_req_type selects
// push, pop or query, s_key_value carries the key. Unused request codes are
// taken and dropped without a result.
// Result channel (m_valid/m_ready): one result per beat; m_last marks the
// final result of a request. Push, pop, overflow and underflow give one beat;
// a query gives one beat per blocking entry (top first) and a final beat with
// m_found set if the key was present.
// Sequencing: one request is in flight at a time. Push, overflow, underflow
// and empty-stack query results are registered on acceptance; a pop first
// reads the top entry from memory. A query scans down from the top one entry
// per cycle until it matches or reaches the bottom, then re-reads the blocking
// entries one per cycle while the output is free, using the single read port.
// Results go through one output register, so a new request is taken as soon
// as the final result of the previous one is in that register and it is free
// or being drained.
// Reset (aresetn low, synchronous) empties the stack and clears the output
// valid flag; entry contents are not cleared. A stalled receiver holds the
// block in place: the pending result and the memory read data stay put.
module stack_with_search_blockers (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_req_type,
    input  logic [sws_pkg::KEY_WIDTH-1:0] s_key_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [2:0]                   m_result_kind,
    output logic                         m_found,
    output logic [sws_pkg::KEY_WIDTH-1:0] m_entry_value,
    output logic                         m_last
);
    import sws_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_WAIT,
        ST_SCAN,
        ST_LIST,
        ST_FIN
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic [PTR_W-1:0]     stop_ptr_reg, stop_ptr_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic                 m_valid_reg, m_valid_next;
    out_beat_t            m_beat_reg, m_beat_next;

    logic                 ram_wr_en;
    logic                 ram_rd_en;
    logic [PTR_W-1:0]     ram_rd_addr;
    logic [KEY_WIDTH-1:0] ram_rd_data;

    logic                 out_free;
    logic                 stack_full;
    logic                 stack_empty;
    logic [CNT_W-1:0]     cnt_dec;
    logic [PTR_W-1:0]     top_ptr;
    logic [PTR_W-1:0]     ptr_dec;

    function automatic out_beat_t make_beat(logic [2:0] kind, logic found,
                                            logic [KEY_WIDTH-1:0] value,
                                            logic last);
        out_beat_t b;
        b.kind  = kind;
        b.found = found;
        b.value = value;
        b.last  = last;
        return b;
    endfunction

    sws_ram u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[PTR_W-1:0]),
        .wr_data (s_key_value),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_free    = !m_valid_reg || m_ready;
    assign stack_full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign stack_empty = (count_reg == '0);
    assign cnt_dec     = count_reg - CNT_W'(1);
    assign top_ptr     = cnt_dec[PTR_W-1:0];
    assign ptr_dec     = ptr_reg - PTR_W'(1);
    assign s_ready     = (state_reg == ST_IDLE) && out_free;

    // Sequence requests; accesses never overlap, so no forwarding is needed
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        stop_ptr_next = stop_ptr_reg;
        key_next      = key_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_beat_next   = m_beat_reg;
        ram_wr_en     = 1'b0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = ptr_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    case (s_req_type)
                        REQ_PUSH: begin
                            m_valid_next = 1'b1;
                            if (stack_full) begin
                                m_beat_next = make_beat(KIND_OVERFLOW, 1'b0, '0, 1'b1);
                            end else begin
                                ram_wr_en   = 1'b1;
                                count_next  = count_reg + CNT_W'(1);
                                m_beat_next = make_beat(KIND_PUSHED, 1'b0, '0, 1'b1);
                            end
                        end
                        REQ_POP: begin
                            if (stack_empty) begin
                                m_valid_next = 1'b1;
                                m_beat_next  = make_beat(KIND_UNDERFLOW, 1'b0, '0, 1'b1);
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = top_ptr;
                                state_next  = ST_POP_WAIT;
                            end
                        end
                        REQ_QUERY: begin
                            if (stack_empty) begin
                                m_valid_next = 1'b1;
                                m_beat_next  = make_beat(KIND_DONE, 1'b0, '0, 1'b1);
                            end else begin
                                key_next    = s_key_value;
                                ptr_next    = top_ptr;
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = top_ptr;
                                state_next  = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_POP_WAIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_beat_next  = make_beat(KIND_POPPED, 1'b0, ram_rd_data, 1'b1);
                    count_next   = cnt_dec;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (ram_rd_data == key_reg) begin
                    if (ptr_reg == top_ptr) begin
                        // match on top: nothing blocks it
                        if (out_free) begin
                            m_valid_next = 1'b1;
                            m_beat_next  = make_beat(KIND_DONE, 1'b1, '0, 1'b1);
                            state_next   = ST_IDLE;
                        end
                    end else begin
                        // restart from the top to list the blockers
                        stop_ptr_next = ptr_reg;
                        ptr_next      = top_ptr;
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = top_ptr;
                        state_next    = ST_LIST;
                    end
                end else if (ptr_reg == '0) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_beat_next  = make_beat(KIND_DONE, 1'b0, '0, 1'b1);
                        state_next   = ST_IDLE;
                    end
                end else begin
                    ptr_next    = ptr_dec;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_dec;
                end
            end
            ST_LIST: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_beat_next  = make_beat(KIND_BLOCKER, 1'b0, ram_rd_data, 1'b0);
                    if (ptr_dec == stop_ptr_reg) begin
                        state_next = ST_FIN;
                    end else begin
                        ptr_next    = ptr_dec;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ptr_dec;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_beat_next  = make_beat(KIND_DONE, 1'b1, '0, 1'b1);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, pointers and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        ptr_reg      <= ptr_next;
        stop_ptr_reg <= stop_ptr_next;
        key_reg      <= key_next;
        m_beat_reg   <= m_beat_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_beat_reg.kind;
    assign m_found       = m_beat_reg.found;
    assign m_entry_value = m_beat_reg.value;
    assign m_last        = m_beat_reg.last;

    // Fill level never passes the memory depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // Accepted push on a non-full stack grows it by one
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req_type == REQ_PUSH && !stack_full)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not grow the stack");

    // Only blocker beats are non-final
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_result_kind != KIND_BLOCKER)))
        else $error("last flag does not match result kind");

    // Found is only set on a finished query
    a_found_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> m_result_kind == KIND_DONE)
        else $error("found flag on a non-query result");

endmodule

// ----- hw/rtl/sws_ram.sv -----
// Stack entry memory: one write port, one registered read port.
module sws_ram (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [sws_pkg::PTR_W-1:0]     wr_addr,
    input  logic [sws_pkg::KEY_WIDTH-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [sws_pkg::PTR_W-1:0]     rd_addr,
    output logic [sws_pkg::KEY_WIDTH-1:0] rd_data
);
    import sws_pkg::*;

    logic [KEY_WIDTH-1:0] mem [STACK_DEPTH];
    logic [KEY_WIDTH-1:0] rd_data_reg;

    // Write on request; read data holds until the next read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
